/* rtl/core/ymas_pkg.sv */
// ----------------------------------------------------------------------------
// ymas_pkg
// Shared widths, register codes and stage types of the y-momentum stencil.
// ----------------------------------------------------------------------------
package ymas_pkg;

   localparam int DATA_W       = 32;   // Q16.16 sample width
   localparam int SUM_W        = DATA_W + 1;
   localparam int ROW_W        = 16;
   localparam int COL_W        = 10;
   localparam int ROW_CNT_W    = 17;   // row counter, saturates
   localparam int MAX_COLS_DEF = 1024;
   localparam int COL_LIM_MAX  = 1021;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_W        = 32;

   localparam logic [COL_W-1:0] GRID_COLS_RST = 10'd64;
   localparam logic [ROW_W-1:0] GRID_ROWS_RST = 16'd64;
   localparam logic [CSR_W-1:0] INV_D_RST     = 32'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLS = 2'd0,
      CSR_GRID_ROWS = 2'd1,
      CSR_INV_DX    = 2'd2,
      CSR_INV_DY    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } ymas_tag_type;

   // operand sums of one time level
   typedef struct packed {
      logic signed [SUM_W-1:0] s_old;
      logic signed [SUM_W-1:0] a_old;
      logic signed [SUM_W-1:0] s_new;
      logic signed [SUM_W-1:0] a_new;
      logic signed [SUM_W-1:0] u;
      logic signed [SUM_W-1:0] v;
   } ymas_lvl_type;

   typedef struct packed {
      ymas_lvl_type [1:0]      lvl;
      logic signed [SUM_W-1:0] dp;
      ymas_tag_type            tag;
   } ymas_ops_type;

   typedef struct packed {
      logic [DATA_W-1:0] y_rhs;
      logic              sat;
      ymas_tag_type      tag;
   } ymas_res_type;

endpackage

/* rtl/core/ymas_chan_if.sv */
// ----------------------------------------------------------------------------
// ymas channel interfaces
// Request (cell) and response (result) valid/ready channels.
// ----------------------------------------------------------------------------
interface ymas_req_if import ymas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] x_vel_prev;
   logic [DATA_W-1:0] y_vel_prev;
   logic [DATA_W-1:0] x_vel_cur;
   logic [DATA_W-1:0] y_vel_cur;
   logic [DATA_W-1:0] pressure;
   logic              frame_start;

   modport source (output valid, x_vel_prev, y_vel_prev, x_vel_cur, y_vel_cur,
                   pressure, frame_start, input ready);
   modport sink   (input valid, x_vel_prev, y_vel_prev, x_vel_cur, y_vel_cur,
                   pressure, frame_start, output ready);
endinterface

interface ymas_rsp_if import ymas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] y_rhs;
   logic [ROW_W-1:0]  out_row;
   logic [COL_W-1:0]  out_col;
   logic              saturated;
   logic              frame_last;

   modport source (output valid, y_rhs, out_row, out_col, saturated, frame_last,
                   input ready);
   modport sink   (input valid, y_rhs, out_row, out_col, saturated, frame_last,
                   output ready);
endinterface

/* rtl/core/ymas_front.sv */
// ----------------------------------------------------------------------------
// ymas_front
// Raster counters, line buffers, stencil window and operand sums.
// ----------------------------------------------------------------------------
module ymas_front import ymas_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              accept,
   input  logic [DATA_W-1:0] x_prev,
   input  logic [DATA_W-1:0] y_prev,
   input  logic [DATA_W-1:0] x_cur,
   input  logic [DATA_W-1:0] y_cur,
   input  logic [DATA_W-1:0] p_in,
   input  logic              frame_start,
   input  logic [COL_W-1:0]  grid_cols,
   input  logic [ROW_W-1:0]  grid_rows,
   output logic              ops_valid,
   output ymas_ops_type      ops
);

   localparam int ADDR_W  = $clog2(MAX_COLS);
   localparam int COL_LIM = (MAX_COLS - 3 < COL_LIM_MAX) ? MAX_COLS - 3 : COL_LIM_MAX;

   function automatic logic [SUM_W-1:0] add2(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
      return {a[DATA_W-1], a} + {b[DATA_W-1], b};
   endfunction

   function automatic logic [SUM_W-1:0] sub2(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
      return {a[DATA_W-1], a} - {b[DATA_W-1], b};
   endfunction

   // ---- request stage: position counters
   logic [ROW_CNT_W-1:0] row_ff, row_in, r, ny1;
   logic [COL_W-1:0]     col_ff, col_in, c_raw, c, nx;
   logic [COL_W:0]       col_end;
   logic                 emit;
   ymas_tag_type         tag0;
   logic [ADDR_W-1:0]    rd_addr;
   logic [DATA_W-1:0]    yin [2];
   logic [DATA_W-1:0]    xin [2];

   always_comb begin
      yin[0]  = y_prev;
      yin[1]  = y_cur;
      xin[0]  = x_prev;
      xin[1]  = x_cur;
      nx      = (32'(grid_cols) > COL_LIM) ? COL_W'(COL_LIM) : grid_cols;
      col_end = {1'b0, nx} + (COL_W+1)'(2);
      ny1     = {1'b0, grid_rows} + ROW_CNT_W'(1);
      r       = frame_start ? '0 : row_ff;
      c_raw   = frame_start ? '0 : col_ff;
      c       = (32'(c_raw) > MAX_COLS - 1) ? COL_W'(MAX_COLS - 1) : c_raw;
      emit    = (r >= ROW_CNT_W'(3)) && (r <= ny1) && (c >= COL_W'(3)) &&
                ({1'b0, c} <= col_end);
      tag0.row  = ROW_W'(r - ROW_CNT_W'(1));
      tag0.col  = c - COL_W'(1);
      tag0.last = (r == ny1) && ({1'b0, c} == col_end);
      rd_addr   = ADDR_W'(c);
      if ({1'b0, c} >= col_end) begin
         col_in = '0;
         row_in = (&r) ? r : r + ROW_CNT_W'(1);
      end else begin
         col_in = c + COL_W'(1);
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---- line buffers: y1 holds row above, y2 two rows above
   logic [DATA_W-1:0] y1_mem [2][MAX_COLS];
   logic [DATA_W-1:0] y2_mem [2][MAX_COLS];
   logic [DATA_W-1:0] x_mem  [2][MAX_COLS];
   logic [DATA_W-1:0] p_mem  [MAX_COLS];
   logic [DATA_W-1:0] a0_ff  [2];
   logic [DATA_W-1:0] b0_ff  [2];
   logic [DATA_W-1:0] xa_ff  [2];
   logic [DATA_W-1:0] pa_ff;

   // stage 1 holding registers
   logic              s1_valid_ff;
   logic              s1_emit_ff;
   ymas_tag_type      s1_tag_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [DATA_W-1:0] s1_y_ff [2];
   logic [DATA_W-1:0] s1_x_ff [2];
   logic [DATA_W-1:0] s1_p_ff;
   logic              upd;

   assign upd = en && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 0; t < 2; t++) begin
            a0_ff[t] <= y1_mem[t][rd_addr];
            b0_ff[t] <= y2_mem[t][rd_addr];
            xa_ff[t] <= x_mem[t][rd_addr];
         end
         pa_ff <= p_mem[rd_addr];
      end
      if (upd) begin
         for (int t = 0; t < 2; t++) begin
            y1_mem[t][s1_addr_ff] <= s1_y_ff[t];
            y2_mem[t][s1_addr_ff] <= a0_ff[t];
            x_mem[t][s1_addr_ff]  <= s1_x_ff[t];
         end
         p_mem[s1_addr_ff] <= s1_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
      if (en) begin
         s1_emit_ff <= emit;
         s1_tag_ff  <= tag0;
         s1_addr_ff <= rd_addr;
         s1_p_ff    <= p_in;
         for (int t = 0; t < 2; t++) begin
            s1_y_ff[t] <= yin[t];
            s1_x_ff[t] <= xin[t];
         end
      end
   end

   // ---- stencil window, shifted once per cell
   logic [DATA_W-1:0] a1_ff [2];
   logic [DATA_W-1:0] a2_ff [2];
   logic [DATA_W-1:0] b1_ff [2];
   logic [DATA_W-1:0] cy_ff [2];
   logic [SUM_W-1:0]  sx1_ff [2];
   logic [SUM_W-1:0]  sx2_ff [2];
   logic [SUM_W-1:0]  d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < 2; t++) begin
            a1_ff[t]  <= '0;
            a2_ff[t]  <= '0;
            b1_ff[t]  <= '0;
            cy_ff[t]  <= '0;
            sx1_ff[t] <= '0;
            sx2_ff[t] <= '0;
         end
         d1_ff <= '0;
      end else if (upd) begin
         for (int t = 0; t < 2; t++) begin
            a2_ff[t]  <= a1_ff[t];
            a1_ff[t]  <= a0_ff[t];
            b1_ff[t]  <= b0_ff[t];
            cy_ff[t]  <= s1_y_ff[t];
            sx2_ff[t] <= sx1_ff[t];
            sx1_ff[t] <= add2(s1_x_ff[t], xa_ff[t]);
         end
         d1_ff <= sub2(s1_p_ff, pa_ff);
      end
   end

   // ---- operand register
   logic         ops_valid_ff;
   ymas_ops_type ops_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ops_valid_ff <= 1'b0;
      end else if (en) begin
         ops_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
      if (en) begin
         for (int t = 0; t < 2; t++) begin
            ops_ff.lvl[t].s_old <= sx2_ff[t];
            ops_ff.lvl[t].a_old <= add2(a2_ff[t], a1_ff[t]);
            ops_ff.lvl[t].s_new <= sx1_ff[t];
            ops_ff.lvl[t].a_new <= add2(a1_ff[t], a0_ff[t]);
            ops_ff.lvl[t].u     <= add2(b1_ff[t], a1_ff[t]);
            ops_ff.lvl[t].v     <= add2(a1_ff[t], cy_ff[t]);
         end
         ops_ff.dp  <= d1_ff;
         ops_ff.tag <= s1_tag_ff;
      end
   end

   assign ops_valid = ops_valid_ff;
   assign ops       = ops_ff;

endmodule

/* rtl/core/ymas_arith.sv */
// ----------------------------------------------------------------------------
// ymas_arith
// Seven-stage fixed-point pipeline: fluxes, scaling, Adams-Bashforth mix,
// pressure term and saturation.
// ----------------------------------------------------------------------------
module ymas_arith import ymas_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              ops_valid,
   input  ymas_ops_type      ops,
   input  logic [CSR_W-1:0]  inv_dx,
   input  logic [CSR_W-1:0]  inv_dy,
   output logic              res_valid,
   output ymas_res_type      res
);

   localparam int NSTG = 7;
   localparam logic signed [81:0] LIM82 = 82'sd1152921504606846976;  // 2^60
   localparam logic signed [62:0] LIM63 = 63'sd1152921504606846976;
   localparam logic signed [64:0] MAX_OUT = 65'sd2147483647;
   localparam logic signed [64:0] MIN_OUT = -65'sd2147483648;

   // product >> 18, round half up
   function automatic logic signed [47:0] rnd18(input logic signed [65:0] p);
      logic signed [65:0] q;
      q = (p + 66'sd131072) >>> 18;
      return q[47:0];
   endfunction

   // split product recombined, >> 16 rounded, clamped to +-2^60
   function automatic logic signed [61:0] scale16(input logic signed [57:0] h,
                                                  input logic signed [57:0] l);
      logic signed [81:0] p;
      logic signed [81:0] q;
      p = $signed({h, 24'b0}) + $signed({{24{l[57]}}, l});
      q = (p + 82'sd32768) >>> 16;
      if (q > LIM82) q = LIM82;
      else if (q < -LIM82) q = -LIM82;
      return q[61:0];
   endfunction

   logic [NSTG-1:0] vld_ff;
   ymas_tag_type    tag_ff [NSTG];

   // stage 0: operand products
   logic signed [65:0] pa_ff [2];
   logic signed [65:0] pb_ff [2];
   logic signed [65:0] pu_ff [2];
   logic signed [65:0] pv_ff [2];
   logic signed [65:0] pd_ff;
   // stage 1: flux differences, pressure term
   logic signed [48:0] f_ff [2];
   logic signed [48:0] g_ff [2];
   logic signed [49:0] pt_ff [5];
   // stage 2: split products with inverse spacing
   logic signed [57:0] fh_ff [2];
   logic signed [57:0] fl_ff [2];
   logic signed [57:0] gh_ff [2];
   logic signed [57:0] gl_ff [2];
   // stage 3..6
   logic signed [61:0] ax_ff [2];
   logic signed [61:0] ay_ff [2];
   logic signed [61:0] s_ff [2];
   logic signed [63:0] half_ff;
   ymas_res_type       res_ff;

   logic signed [62:0] sum_t [2];
   logic signed [64:0] wsum, total;
   logic signed [32:0] dx33, dy33;

   always_comb begin
      dx33 = $signed({1'b0, inv_dx});
      dy33 = $signed({1'b0, inv_dy});
      for (int t = 0; t < 2; t++) begin
         sum_t[t] = ax_ff[t] + ay_ff[t];
         if (sum_t[t] > LIM63) sum_t[t] = LIM63;
         else if (sum_t[t] < -LIM63) sum_t[t] = -LIM63;
      end
      wsum  = (s_ff[1] <<< 1) + s_ff[1] - s_ff[0] + 65'sd1;
      total = half_ff - pt_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], ops_valid};
      end
      if (en) begin
         tag_ff[0] <= ops.tag;
         for (int k = 1; k < NSTG; k++) tag_ff[k] <= tag_ff[k-1];
         for (int k = 1; k < 5; k++) pt_ff[k] <= pt_ff[k-1];
         for (int t = 0; t < 2; t++) begin
            pa_ff[t] <= $signed(ops.lvl[t].s_old) * $signed(ops.lvl[t].a_old);
            pb_ff[t] <= $signed(ops.lvl[t].s_new) * $signed(ops.lvl[t].a_new);
            pu_ff[t] <= $signed(ops.lvl[t].u) * $signed(ops.lvl[t].u);
            pv_ff[t] <= $signed(ops.lvl[t].v) * $signed(ops.lvl[t].v);
            f_ff[t]  <= rnd18(pa_ff[t]) - rnd18(pb_ff[t]);
            g_ff[t]  <= rnd18(pu_ff[t]) - rnd18(pv_ff[t]);
            fh_ff[t] <= $signed(f_ff[t][48:24]) * dx33;
            fl_ff[t] <= $signed({1'b0, f_ff[t][23:0]}) * dx33;
            gh_ff[t] <= $signed(g_ff[t][48:24]) * dy33;
            gl_ff[t] <= $signed({1'b0, g_ff[t][23:0]}) * dy33;
            ax_ff[t] <= scale16(fh_ff[t], fl_ff[t]);
            ay_ff[t] <= scale16(gh_ff[t], gl_ff[t]);
            s_ff[t]  <= sum_t[t][61:0];
         end
         pd_ff    <= $signed(ops.dp) * dy33;
         pt_ff[0] <= 50'((pd_ff + 66'sd32768) >>> 16);
         half_ff  <= 64'(wsum >>> 1);
         res_ff.tag <= tag_ff[5];
         if (total > MAX_OUT) begin
            res_ff.y_rhs <= MAX_OUT[DATA_W-1:0];
            res_ff.sat   <= 1'b1;
         end else if (total < MIN_OUT) begin
            res_ff.y_rhs <= MIN_OUT[DATA_W-1:0];
            res_ff.sat   <= 1'b1;
         end else begin
            res_ff.y_rhs <= total[DATA_W-1:0];
            res_ff.sat   <= 1'b0;
         end
      end
   end

   assign res_valid = vld_ff[NSTG-1];
   assign res       = res_ff;

endmodule

/* rtl/core/ymas_skid.sv */
// ----------------------------------------------------------------------------
// ymas_skid
// Two-entry result buffer between the pipeline and the response channel.
// ----------------------------------------------------------------------------
module ymas_skid import ymas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ymas_res_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         out_valid,
   output ymas_res_type out_data
);

   ymas_res_type ent_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
      if (push) ent_ff[wr_ptr_ff] <= push_data;
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = ent_ff[rd_ptr_ff];

endmodule

/* rtl/core/y_momentum_advection_stencil.sv */
// ----------------------------------------------------------------------------
// y_momentum_advection_stencil
// Streaming y-momentum right-hand side on a staggered grid, Q16.16.
// ----------------------------------------------------------------------------
// Cells stream in raster order, one per clock when both sides keep up; a
// frame is grid_rows+2 rows of grid_cols+3 cells and frame_start marks its
// first cell. The result for interior cell (j,i) leaves when cell (j+1,i+1)
// has been taken, passing through the line buffer read, operand,
// seven arithmetic stages and the output buffer. The whole pipeline moves on
// one enable that drops only when the two-entry output buffer is full, so a
// stalled response side holds every stage and nothing is lost or repeated.
// Line buffers need no clearing after reset; program the CSRs only while the
// block is idle.
// ----------------------------------------------------------------------------
module y_momentum_advection_stencil import ymas_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ymas_req_if.sink             req_chan,
   ymas_rsp_if.source           rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   // configuration registers
   logic [COL_W-1:0] grid_cols_ff;
   logic [ROW_W-1:0] grid_rows_ff;
   logic [CSR_W-1:0] inv_dx_ff, inv_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_COLS_RST;
         grid_rows_ff <= GRID_ROWS_RST;
         inv_dx_ff    <= INV_D_RST;
         inv_dy_ff    <= INV_D_RST;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_GRID_COLS: grid_cols_ff <= csr_wr_data[COL_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wr_data[ROW_W-1:0];
            CSR_INV_DX:    inv_dx_ff    <= csr_wr_data;
            CSR_INV_DY:    inv_dy_ff    <= csr_wr_data;
            default:       ;
         endcase
      end
   end

   // global pipeline enable: stop only when the output buffer is full
   logic         en, accept, buf_full;
   logic         ops_valid, res_valid, out_valid;
   ymas_ops_type ops;
   ymas_res_type res, out_data;

   assign en             = !buf_full;
   assign req_chan.ready = en;
   assign accept         = req_chan.valid && en;

   ymas_front #(.MAX_COLS(MAX_COLS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .accept      (accept),
      .x_prev      (req_chan.x_vel_prev),
      .y_prev      (req_chan.y_vel_prev),
      .x_cur       (req_chan.x_vel_cur),
      .y_cur       (req_chan.y_vel_cur),
      .p_in        (req_chan.pressure),
      .frame_start (req_chan.frame_start),
      .grid_cols   (grid_cols_ff),
      .grid_rows   (grid_rows_ff),
      .ops_valid   (ops_valid),
      .ops         (ops)
   );

   ymas_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ops_valid (ops_valid),
      .ops       (ops),
      .inv_dx    (inv_dx_ff),
      .inv_dy    (inv_dy_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   ymas_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid && en),
      .push_data (res),
      .pop       (rsp_chan.valid && rsp_chan.ready),
      .full      (buf_full),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   assign rsp_chan.valid      = out_valid;
   assign rsp_chan.y_rhs      = out_data.y_rhs;
   assign rsp_chan.out_row    = out_data.tag.row;
   assign rsp_chan.out_col    = out_data.tag.col;
   assign rsp_chan.saturated  = out_data.sat;
   assign rsp_chan.frame_last = out_data.tag.last;

   // a finished result held by a stall stays in the last stage
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid && !en |=> res_valid)
      else $error("result dropped from pipeline tail during stall");

   // a result leaving the pipeline lands in the output buffer
   a_tail_push: assert property (@(posedge clock) disable iff (reset)
      res_valid && en |=> rsp_chan.valid)
      else $error("pipeline result not visible on response channel");

   // only interior cells produce results
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.out_row >= 16'd2) && (rsp_chan.out_col >= 10'd2))
      else $error("result issued for a border cell");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams raster frames of staggered-grid cells through the y-momentum
// stencil and checks every result against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
   import ymas_pkg::*;

   localparam int  HALF_PERIOD = 2;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  ITEM_TARGET = 1050;
   localparam int  DRAIN_WAIT  = 24;     // pipeline depth plus margin
   localparam int  LINE_COLS   = 1024;
   localparam longint CLIP     = 64'sd1 << 60;
   localparam int  ROW_CAP     = 32'h20000;

   // window register slots of one time level
   localparam int WA1 = 0, WA2 = 1, WB1 = 2, WCY1 = 3, WS1 = 4, WS2 = 5, WD1 = 12;

   typedef struct {
      logic [DATA_W-1:0] x_prev, y_prev, x_cur, y_cur, pres;
      bit                start;
   } cell_type;

   typedef struct {
      logic [DATA_W-1:0] y_rhs;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      bit                sat;
      bit                last;
   } rhs_type;

   // -------------------------------------------------------------------------
   // scoreboard: owns the predictor state and the queue of expected results
   // -------------------------------------------------------------------------
   class rhs_scoreboard;
      longint        y_lines [2][2*LINE_COLS];
      longint        x_line  [2][LINE_COLS];
      longint        p_line  [LINE_COLS];
      longint        win     [16];
      int unsigned   row_cnt, col_cnt;
      int unsigned   cols, rows;
      logic [31:0]   inv_dx, inv_dy;
      rhs_type       pending_rhs [$];
      int            errors;

      function new();
         foreach (y_lines[t, k]) y_lines[t][k] = 0;
         foreach (x_line[t, k])  x_line[t][k] = 0;
         foreach (p_line[k])     p_line[k] = 0;
         foreach (win[k])        win[k] = 0;
         row_cnt = 0; col_cnt = 0;
         cols = 64; rows = 64;
         inv_dx = 65536; inv_dy = 65536;
         errors = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [31:0] val);
         case (idx)
            CSR_GRID_COLS: cols = val[9:0];
            CSR_GRID_ROWS: rows = val[15:0];
            CSR_INV_DX:    inv_dx = val;
            CSR_INV_DY:    inv_dy = val;
            default: ;
         endcase
      endfunction

      // a*b >> sh, round half up, clipped to +-2^60
      function longint scale_mul(longint a, longint b, int sh);
         logic [127:0] ua, ub, p;
         bit           neg;
         neg = (a < 0) != (b < 0);
         ua  = (a < 0) ? 128'(-a) : 128'(a);
         ub  = (b < 0) ? 128'(-b) : 128'(b);
         p   = ua * ub + (128'd1 << (sh - 1)) - (neg ? 128'd1 : 128'd0);
         p   = p >> sh;
         if (p > 128'(CLIP)) p = 128'(CLIP);
         return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
      endfunction

      function longint clip60(longint v);
         if (v > CLIP) return CLIP;
         if (v < -CLIP) return -CLIP;
         return v;
      endfunction

      // advection of one time level, a0 = y one row up at the next column
      function longint advect(int t, longint a0);
         int     b;
         longint f, g, u, v, ax, ay;
         b  = 6 * t;
         f  = scale_mul(win[b+WS2], win[b+WA2] + win[b+WA1], 18)
            - scale_mul(win[b+WS1], win[b+WA1] + a0, 18);
         ax = scale_mul(f, longint'({32'd0, inv_dx}), 16);
         u  = win[b+WB1] + win[b+WA1];
         v  = win[b+WA1] + win[b+WCY1];
         g  = scale_mul(u, u, 18) - scale_mul(v, v, 18);
         ay = scale_mul(g, longint'({32'd0, inv_dy}), 16);
         return clip60(ax + ay);
      endfunction

      function void note_request(cell_type grid_pt);
         int unsigned nx, r, c;
         longint      xin[2], yin[2], a0[2], b0[2], xa[2], pin, pa, s1, s2, ws, hf, res;
         rhs_type     e;
         nx = (cols > COL_LIM_MAX) ? COL_LIM_MAX : cols;
         r  = grid_pt.start ? 0 : row_cnt;
         c  = grid_pt.start ? 0 : col_cnt;
         if (c >= LINE_COLS) c = LINE_COLS - 1;
         xin[0] = longint'(signed'(grid_pt.x_prev));
         yin[0] = longint'(signed'(grid_pt.y_prev));
         xin[1] = longint'(signed'(grid_pt.x_cur));
         yin[1] = longint'(signed'(grid_pt.y_cur));
         pin    = longint'(signed'(grid_pt.pres));
         for (int t = 0; t < 2; t++) begin
            a0[t] = y_lines[t][c];
            b0[t] = y_lines[t][LINE_COLS + c];
            xa[t] = x_line[t][c];
         end
         pa = p_line[c];

         // interior cells only; the result belongs to the cell up and left
         if (r >= 3 && r <= rows + 1 && c >= 3 && c <= nx + 2) begin
            s1 = advect(0, a0[0]);
            s2 = advect(1, a0[1]);
            ws = 3 * s2 - s1 + 1;
            hf = (ws >= 0) ? ws / 2 : -((1 - ws) / 2);
            res = hf - scale_mul(win[WD1], longint'({32'd0, inv_dy}), 16);
            e.sat = 0;
            if (res > 64'sd2147483647) begin res = 64'sd2147483647; e.sat = 1; end
            if (res < -64'sd2147483648) begin res = -64'sd2147483648; e.sat = 1; end
            e.y_rhs = res[31:0];
            e.row   = 16'(r - 1);
            e.col   = 10'(c - 1);
            e.last  = (r - 1 == rows) && (c - 1 == nx + 1);
            pending_rhs.push_back(e);
         end

         for (int t = 0; t < 2; t++) begin
            y_lines[t][LINE_COLS + c] = a0[t];
            y_lines[t][c] = yin[t];
            x_line[t][c]  = xin[t];
            win[6*t+WA2]  = win[6*t+WA1];
            win[6*t+WA1]  = a0[t];
            win[6*t+WB1]  = b0[t];
            win[6*t+WCY1] = yin[t];
            win[6*t+WS2]  = win[6*t+WS1];
            win[6*t+WS1]  = xin[t] + xa[t];
         end
         p_line[c] = pin;
         win[WD1]  = pin - pa;

         if (c >= nx + 2) begin
            col_cnt = 0;
            row_cnt = (r < ROW_CAP) ? r + 1 : ROW_CAP;
         end else begin
            col_cnt = c + 1;
            row_cnt = r;
         end
      endfunction

      function void check_response(rhs_type got);
         rhs_type e;
         if (pending_rhs.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result row %0d col %0d y_rhs %h", got.row, got.col,
                        got.y_rhs);
            return;
         end
         e = pending_rhs.pop_front();
         if (got.y_rhs !== e.y_rhs || got.row !== e.row || got.col !== e.col ||
             got.sat !== e.sat || got.last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display({"result mismatch: exp rhs %h row %0d col %0d sat %0b last %0b,",
                         " got rhs %h row %0d col %0d sat %0b last %0b"},
                        e.y_rhs, e.row, e.col, e.sat, e.last,
                        got.y_rhs, got.row, got.col, got.sat, got.last);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, DUT
   // -------------------------------------------------------------------------
   logic clock = 0;
   logic reset = 1;
   logic                 csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GRID_COLS;
   logic [CSR_W-1:0]     csr_wr_data = '0;

   always #HALF_PERIOD clock = ~clock;

   ymas_req_if req_if ();
   ymas_rsp_if rsp_if ();

   y_momentum_advection_stencil dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rhs_scoreboard sb = new();
   int  cycles = 0;
   int  items  = 0;
   int  rx_hold = 0;     // long response-side hold-off, in cycles
   bit  quiet = 0;       // no random gaps on either side while set

   initial begin
      req_if.valid = 0;
      req_if.x_vel_prev = '0; req_if.y_vel_prev = '0;
      req_if.x_vel_cur = '0;  req_if.y_vel_cur = '0;
      req_if.pressure = '0;   req_if.frame_start = 0;
      rsp_if.ready = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // response side: random stalls plus the long hold-off when requested
   initial begin : rsp_driver
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_if.ready = 0;
            rx_hold--;
         end else if (stall > 0) begin
            rsp_if.ready = 0;
            stall--;
         end else begin
            rsp_if.ready = 1;
            stall = pick_gap();
         end
      end
   end

   // sample accepted results at the rising edge
   always @(posedge clock) begin
      rhs_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.y_rhs = rsp_if.y_rhs;
         got.row   = rsp_if.out_row;
         got.col   = rsp_if.out_col;
         got.sat   = rsp_if.saturated;
         got.last  = rsp_if.frame_last;
         sb.check_response(got);
      end
   end

   // -------------------------------------------------------------------------
   // request side tasks
   // -------------------------------------------------------------------------
   task automatic send_cell(cell_type grid_pt);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 0;
      end
      @(negedge clock);
      req_if.x_vel_prev  = grid_pt.x_prev;
      req_if.y_vel_prev  = grid_pt.y_prev;
      req_if.x_vel_cur   = grid_pt.x_cur;
      req_if.y_vel_cur   = grid_pt.y_cur;
      req_if.pressure    = grid_pt.pres;
      req_if.frame_start = grid_pt.start;
      req_if.valid       = 1;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(grid_pt);
      items++;
   endtask

   task automatic csr_write(csr_idx_type idx, logic [31:0] val);
      @(negedge clock);
      req_if.valid = 0;
      csr_wr_en    = 1;
      csr_index    = idx;
      csr_wr_data  = val;
      @(negedge clock);
      csr_wr_en    = 0;
      sb.set_reg(idx, val);
   endtask

   // wait for every expected result, then let the pipeline go quiet
   task automatic drain();
      @(negedge clock);
      req_if.valid = 0;
      while (sb.pending_rhs.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 7))
         0, 1:    return $urandom;
         2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         3, 4:    return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
         default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      endcase
   endfunction

   function automatic logic [31:0] rand_inv();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hffffffff;
         2:       return $urandom;
         3, 4:    return 32'd65536;
         default: return $urandom_range(1, 1 << 20);
      endcase
   endfunction

   function automatic cell_type rand_cell(bit start);
      cell_type grid_pt;
      grid_pt.x_prev = rand_val(); grid_pt.y_prev = rand_val();
      grid_pt.x_cur  = rand_val(); grid_pt.y_cur  = rand_val();
      grid_pt.pres   = rand_val();
      grid_pt.start  = start;
      return grid_pt;
   endfunction

   // one frame; cut > 0 ends it early (a broken frame), extra adds trailing cells
   task automatic send_frame(int cut, int extra, int pause_at);
      int nx, total;
      nx    = (sb.cols > COL_LIM_MAX) ? COL_LIM_MAX : sb.cols;
      total = (sb.rows + 2) * (nx + 3);
      if (cut > 0 && cut < total) total = cut;
      for (int k = 0; k < total + extra; k++) begin
         if (k == pause_at) begin
            @(negedge clock);
            req_if.valid = 0;
            while (sb.pending_rhs.size() != 0) @(posedge clock);
         end
         send_cell(rand_cell(k == 0));
      end
   endtask

   task automatic random_config();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)      csr_write(CSR_GRID_COLS, $urandom_range(0, 1));
      else if (r == 1) csr_write(CSR_GRID_COLS, 12);
      else             csr_write(CSR_GRID_COLS, $urandom_range(1, 8));
      csr_write(CSR_GRID_ROWS, ($urandom_range(0, 15) == 0) ? 1 : $urandom_range(2, 6));
      csr_write(CSR_INV_DX, rand_inv());
      csr_write(CSR_INV_DY, rand_inv());
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      cell_type grid_pt;
      int       frame;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: 2x2 interior, alternating extreme samples to force clipping
      csr_write(CSR_GRID_COLS, 2);
      csr_write(CSR_GRID_ROWS, 2);
      csr_write(CSR_INV_DX, 32'hffffffff);
      csr_write(CSR_INV_DY, 32'hffffffff);
      for (int k = 0; k < 20; k++) begin
         grid_pt.x_prev = (k % 2) ? 32'h7fffffff : 32'h80000000;
         grid_pt.y_prev = (k % 3) ? 32'h80000000 : 32'h7fffffff;
         grid_pt.x_cur  = (k % 2) ? 32'h80000000 : 32'h7fffffff;
         grid_pt.y_cur  = (k % 4 < 2) ? 32'h7fffffff : 32'h80000000;
         grid_pt.pres   = (k % 5) ? 32'h00000000 : 32'h80000000;
         grid_pt.start  = (k == 0);
         send_cell(grid_pt);
      end
      drain();

      // tall grid: only a few rows streamed before a restart
      csr_write(CSR_GRID_ROWS, 16'hffff);
      csr_write(CSR_GRID_COLS, 2);
      csr_write(CSR_INV_DX, 32'd65536);
      csr_write(CSR_INV_DY, 32'd0);
      send_frame(5 * 7, 0, -1);
      drain();
      random_config();

      frame = 0;
      while (items < ITEM_TARGET) begin
         if ($urandom_range(0, 2) != 0) begin
            drain();
            random_config();
         end
         quiet = ($urandom_range(0, 4) == 0);
         if (frame == 3) begin
            // a frame with many results, so the held-off output backs up
            drain();
            csr_write(CSR_GRID_COLS, 8);
            csr_write(CSR_GRID_ROWS, 6);
            quiet   = 1;
            rx_hold = 300;    // fill the pipeline and stall the input
         end
         send_frame((frame != 3 && $urandom_range(0, 7) == 0) ? $urandom_range(2, 30) : 0,
                    ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0,
                    (frame == 5) ? 20 : -1);
         frame++;
      end

      drain();
      if (sb.errors == 0 && sb.pending_rhs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
